// ===== rtl/i2cmrb_pkg.sv =====
package i2cmrb_pkg;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int DEV_W      = 7;
    localparam int REG_W      = 8;
    localparam int LEN_W      = 5;
    localparam int BUF_IDX_W  = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int BUF_DEPTH         = 1 << BUF_IDX_W;
    localparam int DEF_MAX_BURST     = 16;
    localparam int DEF_QUEUE_DEPTH   = 2;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [7:0] DELAY_TICKS_RST = 8'd1;

    // Opcodes on the command channel
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd3;

    // Command classes after decode
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 1'd1;

    // Decoded command held in the queue
    typedef struct packed {
        logic [1:0]           kind;
        logic                 is_read;
        logic                 sda;
        logic [DEV_W-1:0]     dev;
        logic [REG_W-1:0]     regaddr;
        logic [LEN_W-1:0]     len;
        logic [BUF_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    data;
    } t_cmd;

    // Queue head as seen by the engine
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    // One result beat
    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_is_output;
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
        logic              read_last;
        logic              done_res;
        logic              status;
        logic              busy_res;
    } t_res;

endpackage

// ===== rtl/i2cmrb_cmd_if.sv =====
interface i2cmrb_cmd_if;
    import i2cmrb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic                 sda_sample;
    logic [DEV_W-1:0]     device_address;
    logic [REG_W-1:0]     register_address;
    logic [LEN_W-1:0]     burst_length;
    logic [BUF_IDX_W-1:0] buffer_index;
    logic [BYTE_W-1:0]    data_byte;

    modport source (
        output valid, opcode, sda_sample, device_address, register_address,
               burst_length, buffer_index, data_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, sda_sample, device_address, register_address,
               burst_length, buffer_index, data_byte,
        output ready
    );
endinterface

// ===== rtl/i2cmrb_res_if.sv =====
interface i2cmrb_res_if;
    import i2cmrb_pkg::*;

    logic              valid;
    logic              ready;
    logic              scl;
    logic              sda_out;
    logic              sda_is_output;
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
    logic              read_last;
    logic              done_res;
    logic              status;
    logic              busy_res;

    modport source (
        output valid, scl, sda_out, sda_is_output, read_valid, read_data,
               read_last, done_res, status, busy_res,
        input  ready
    );
    modport sink (
        input  valid, scl, sda_out, sda_is_output, read_valid, read_data,
               read_last, done_res, status, busy_res,
        output ready
    );
endinterface

// ===== rtl/i2cmrb_cfg_if.sv =====
interface i2cmrb_cfg_if;
    import i2cmrb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/i2cmrb_front.sv =====
module i2cmrb_front #(
    parameter int MAX_BURST = i2cmrb_pkg::DEF_MAX_BURST
) (
    i2cmrb_cmd_if.sink         i_cmd,
    input  logic               i_q_full,
    output logic               o_push,
    output i2cmrb_pkg::t_cmd   o_cmd
);
    import i2cmrb_pkg::*;

    localparam int LIM_W = (LEN_W > 8 ? LEN_W : 8) + 1;

    logic [LIM_W-1:0] len_ext;
    logic [LIM_W-1:0] max_ext;

    assign len_ext = LIM_W'(i_cmd.burst_length);
    assign max_ext = LIM_W'(MAX_BURST);

    assign i_cmd.ready = !i_q_full;
    assign o_push      = i_cmd.valid && !i_q_full;

    always_comb begin
        o_cmd         = '0;
        o_cmd.sda     = i_cmd.sda_sample;
        o_cmd.dev     = i_cmd.device_address;
        o_cmd.regaddr = i_cmd.register_address;
        o_cmd.idx     = i_cmd.buffer_index;
        o_cmd.data    = i_cmd.data_byte;
        // clamp burst to the configured maximum
        o_cmd.len     = (len_ext > max_ext) ? LEN_W'(max_ext) : i_cmd.burst_length;
        unique case (i_cmd.opcode)
            OP_TICK:  o_cmd.kind = KIND_TICK;
            OP_LOAD:  o_cmd.kind = KIND_LOAD;
            OP_WRITE: o_cmd.kind = KIND_START;
            OP_READ: begin
                o_cmd.kind    = KIND_START;
                o_cmd.is_read = 1'b1;
            end
            default:  o_cmd.kind = KIND_TICK;
        endcase
    end

endmodule

// ===== rtl/i2cmrb_queue.sv =====
module i2cmrb_queue #(
    parameter int DEPTH = i2cmrb_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  i2cmrb_pkg::t_cmd   i_cmd,
    input  logic               i_pop,
    output logic               o_full,
    output i2cmrb_pkg::t_head  o_head
);
    import i2cmrb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop  ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/i2cmrb_engine.sv =====
module i2cmrb_engine #(
    parameter int MAX_BURST = i2cmrb_pkg::DEF_MAX_BURST
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cmrb_cfg_if.sink         i_cfg,
    input  i2cmrb_pkg::t_head  i_head,
    output logic               o_pop,
    i2cmrb_res_if.source       o_res
);
    import i2cmrb_pkg::*;

    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam int BT_MAX  = (MAX_BURST < LEN_MAX) ? MAX_BURST : LEN_MAX;
    localparam int CNT_RAW = $clog2(BT_MAX + 4);
    localparam int CNT_W   = (CNT_RAW > BUF_IDX_W) ? CNT_RAW : BUF_IDX_W + 1;

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST1  = 5'd1;
    localparam logic [4:0] PH_ST2  = 5'd2;
    localparam logic [4:0] PH_TXL  = 5'd3;
    localparam logic [4:0] PH_TXH  = 5'd4;
    localparam logic [4:0] PH_AKL  = 5'd5;
    localparam logic [4:0] PH_AKH  = 5'd6;
    localparam logic [4:0] PH_AKW  = 5'd7;
    localparam logic [4:0] PH_RXL  = 5'd8;
    localparam logic [4:0] PH_RXH  = 5'd9;
    localparam logic [4:0] PH_MAL  = 5'd10;
    localparam logic [4:0] PH_MAH  = 5'd11;
    localparam logic [4:0] PH_SP1  = 5'd12;
    localparam logic [4:0] PH_SP2  = 5'd13;
    localparam logic [4:0] PH_SP3  = 5'd14;
    localparam logic [4:0] PH_EP1  = 5'd15;
    localparam logic [4:0] PH_EP2  = 5'd16;
    localparam logic [4:0] PH_EP3  = 5'd17;

    logic [7:0]        r_ack_timeout;
    logic [7:0]        r_delay_ticks;

    logic [4:0]        r_phase, n_phase;
    logic [3:0]        r_bit,   n_bit;
    logic [7:0]        r_shift, n_shift;
    logic [CNT_W-1:0]  r_byte,  n_byte;
    logic [LEN_W-1:0]  r_bt,    n_bt;
    logic [DEV_W-1:0]  r_dev,   n_dev;
    logic [REG_W-1:0]  r_reg,   n_reg;
    logic              r_isrd,  n_isrd;
    logic [7:0]        r_ackw,  n_ackw;
    logic [7:0]        r_slot,  n_slot;

    logic [BYTE_W-1:0] r_wbuf [BUF_DEPTH];

    logic              r_out_valid;
    t_res              r_out, n_out;

    logic              fire;
    logic [CNT_W-1:0]  bc1;
    logic [CNT_W-1:0]  bt_ext;
    logic [CNT_W-1:0]  wb_pos;
    logic [BYTE_W-1:0] wb_data;
    logic [7:0]        delay_eff;
    logic [8:0]        slot_inc;
    logic              slot_end;
    logic [3:0]        bit_inc;
    logic [7:0]        rx_shift;

    assign i_cfg.ready = 1'b1;

    assign fire  = i_head.valid && (!r_out_valid || o_res.ready);
    assign o_pop = fire;

    assign bc1       = r_byte + CNT_W'(1);
    assign bt_ext    = CNT_W'(r_bt);
    assign wb_pos    = bc1 - CNT_W'(2);
    assign wb_data   = r_wbuf[wb_pos[BUF_IDX_W-1:0]];
    assign delay_eff = (r_delay_ticks == 8'd0) ? 8'd1 : r_delay_ticks;
    assign slot_inc  = {1'b0, r_slot} + 9'd1;
    assign slot_end  = (slot_inc >= {1'b0, delay_eff});
    assign bit_inc   = r_bit + 4'd1;
    assign rx_shift  = {r_shift[6:0], i_head.cmd.sda};

    // next state for the item at the queue head
    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_byte  = r_byte;
        n_bt    = r_bt;
        n_dev   = r_dev;
        n_reg   = r_reg;
        n_isrd  = r_isrd;
        n_ackw  = r_ackw;
        n_slot  = r_slot;
        n_out   = '0;

        if (fire) begin
            unique case (i_head.cmd.kind)
                KIND_TICK: begin
                    if (r_phase == PH_AKW) begin
                        if (!i_head.cmd.sda) begin
                            // ack seen: choose what follows
                            n_byte = bc1;
                            n_slot = '0;
                            if (bc1 == CNT_W'(1)) begin
                                n_shift = r_reg;
                                n_bit   = '0;
                                n_phase = PH_TXL;
                            end else if (!r_isrd) begin
                                if (bc1 >= bt_ext + CNT_W'(2)) begin
                                    n_phase = PH_SP1;
                                end else begin
                                    n_shift = wb_data;
                                    n_bit   = '0;
                                    n_phase = PH_TXL;
                                end
                            end else if (bc1 == CNT_W'(2)) begin
                                n_phase = PH_ST1;
                            end else if (r_bt == '0) begin
                                n_phase = PH_SP1;
                            end else begin
                                n_bit   = '0;
                                n_shift = '0;
                                n_phase = PH_RXL;
                            end
                        end else if (r_ackw >= r_ack_timeout) begin
                            n_phase = PH_EP1;
                            n_slot  = '0;
                        end else begin
                            n_ackw = r_ackw + 8'd1;
                        end
                    end else if (r_phase != PH_IDLE) begin
                        if (!slot_end) begin
                            n_slot = slot_inc[7:0];
                        end else begin
                            n_slot = '0;
                            unique case (r_phase)
                                PH_ST1: n_phase = PH_ST2;
                                PH_ST2: begin
                                    n_shift = {r_dev, (r_byte == CNT_W'(2))};
                                    n_bit   = '0;
                                    n_phase = PH_TXL;
                                end
                                PH_TXL: n_phase = PH_TXH;
                                PH_TXH: begin
                                    n_bit   = bit_inc;
                                    n_shift = {r_shift[6:0], 1'b0};
                                    n_phase = (bit_inc >= 4'd8) ? PH_AKL : PH_TXL;
                                end
                                PH_AKL: n_phase = PH_AKH;
                                PH_AKH: begin
                                    n_ackw  = '0;
                                    n_phase = PH_AKW;
                                end
                                PH_RXL: n_phase = PH_RXH;
                                PH_RXH: begin
                                    n_shift = rx_shift;
                                    n_bit   = bit_inc;
                                    if (bit_inc >= 4'd8) begin
                                        n_byte               = bc1;
                                        n_out.read_valid     = 1'b1;
                                        n_out.read_data      = rx_shift;
                                        n_out.read_last      = (bc1 >= bt_ext + CNT_W'(3));
                                        n_phase              = PH_MAL;
                                    end else begin
                                        n_phase = PH_RXL;
                                    end
                                end
                                PH_MAL: n_phase = PH_MAH;
                                PH_MAH: begin
                                    if (r_byte >= bt_ext + CNT_W'(3)) begin
                                        n_phase = PH_SP1;
                                    end else begin
                                        n_bit   = '0;
                                        n_shift = '0;
                                        n_phase = PH_RXL;
                                    end
                                end
                                PH_SP1: n_phase = PH_SP2;
                                PH_SP2: n_phase = PH_SP3;
                                PH_SP3: begin
                                    n_out.done_res = 1'b1;
                                    n_phase        = PH_IDLE;
                                end
                                PH_EP1: n_phase = PH_EP2;
                                PH_EP2: n_phase = PH_EP3;
                                PH_EP3: begin
                                    n_out.done_res = 1'b1;
                                    n_out.status   = 1'b1;
                                    n_phase        = PH_IDLE;
                                end
                                default: n_phase = PH_IDLE;
                            endcase
                        end
                    end
                end
                KIND_LOAD: begin
                    // buffer write happens in the clocked block
                end
                KIND_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_dev   = i_head.cmd.dev;
                        n_reg   = i_head.cmd.regaddr;
                        n_bt    = i_head.cmd.len;
                        n_isrd  = i_head.cmd.is_read;
                        n_byte  = '0;
                        n_bit   = '0;
                        n_shift = '0;
                        n_ackw  = '0;
                        n_slot  = '0;
                        n_phase = PH_ST1;
                    end
                end
                default: begin
                end
            endcase
        end

        // bus lines after this beat
        n_out.scl           = 1'b1;
        n_out.sda_out       = 1'b1;
        n_out.sda_is_output = 1'b1;
        n_out.busy_res      = (n_phase != PH_IDLE);
        unique case (n_phase)
            PH_ST2: n_out.sda_out = 1'b0;
            PH_TXL: begin
                n_out.scl     = 1'b0;
                n_out.sda_out = n_shift[7];
            end
            PH_TXH: n_out.sda_out = n_shift[7];
            PH_AKL, PH_RXL: begin
                n_out.scl           = 1'b0;
                n_out.sda_is_output = 1'b0;
            end
            PH_AKH, PH_AKW, PH_RXH: n_out.sda_is_output = 1'b0;
            PH_MAL, PH_MAH: begin
                n_out.scl     = (n_phase == PH_MAH);
                n_out.sda_out = (n_byte >= CNT_W'(n_bt) + CNT_W'(3));
            end
            PH_SP1, PH_EP1: begin
                n_out.scl     = 1'b0;
                n_out.sda_out = 1'b0;
            end
            PH_SP2, PH_EP2: n_out.sda_out = 1'b0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fire && (i_head.cmd.kind == KIND_LOAD)) begin
            r_wbuf[i_head.cmd.idx] <= i_head.cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
            r_delay_ticks <= DELAY_TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg.data;
                CFG_DELAY_TICKS: r_delay_ticks <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit       <= '0;
            r_shift     <= '0;
            r_byte      <= '0;
            r_bt        <= '0;
            r_dev       <= '0;
            r_reg       <= '0;
            r_isrd      <= 1'b0;
            r_ackw      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_byte  <= n_byte;
            r_bt    <= n_bt;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
            r_isrd  <= n_isrd;
            r_ackw  <= n_ackw;
            r_slot  <= n_slot;
            if (!r_out_valid || o_res.ready) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.scl           = r_out.scl;
    assign o_res.sda_out       = r_out.sda_out;
    assign o_res.sda_is_output = r_out.sda_is_output;
    assign o_res.read_valid    = r_out.read_valid;
    assign o_res.read_data     = r_out.read_data;
    assign o_res.read_last     = r_out.read_last;
    assign o_res.done_res      = r_out.done_res;
    assign o_res.status        = r_out.status;
    assign o_res.busy_res      = r_out.busy_res;

endmodule

// ===== rtl/i2c_master_register_burst_top.sv =====
// A command beat accepted is written into the command queue, then the bus engine steps it
//   into the output register. Throughput: one beat per clock unless a result beat stalls;
//   every command, ticks included, is one engine step.
// Reset: synchronous, active low; clears bus phase, counters, queue and output valid,
//   and sets ack_timeout to 250 and delay_ticks to 1. The write buffer is not cleared.
module i2c_master_register_burst_top #(
    parameter int MAX_BURST   = i2cmrb_pkg::DEF_MAX_BURST,
    parameter int QUEUE_DEPTH = i2cmrb_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cmrb_cmd_if.sink    i_cmd,
    i2cmrb_cfg_if.sink    i_cfg,
    i2cmrb_res_if.source  o_res
);
    import i2cmrb_pkg::*;

    // front side: handshake, opcode decode, burst clamp
    logic  push;
    logic  q_full;
    t_cmd  front_cmd;

    // back side: queue head and pop
    t_head head;
    logic  pop;

    i2cmrb_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    // short queue decouples the accepting side from the bus engine so a
    // stalled result beat does not stop the input immediately
    i2cmrb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // bus engine: phase machine, slot timer, ack watch, shifter, write buffer,
    // config registers and the registered result beat
    i2cmrb_engine #(
        .MAX_BURST (MAX_BURST)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/i2cmrb_checker.sv =====
module i2cmrb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_sda_out,
    input logic       i_sda_is_output,
    input logic       i_read_valid,
    input logic [7:0] i_read_data,
    input logic       i_read_last,
    input logic       i_done_res,
    input logic       i_status,
    input logic       i_busy_res
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_read_data) && $stable(i_done_res)
                                && $stable(i_busy_res))
        else $error("result beat changed while stalled");

    // a finished transaction leaves the bus free
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_done_res |-> !i_busy_res && !i_read_valid)
        else $error("done with bus still busy");

    // error status only on completion
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status |-> i_done_res)
        else $error("status without done");

    // released SDA reads as high
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_sda_is_output |-> i_sda_out && i_busy_res)
        else $error("SDA released but driven low or idle");

    // last flag only on a received byte inside a transaction
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_read_last |-> i_read_valid && i_busy_res)
        else $error("read_last without read_valid");

endmodule

bind i2c_master_register_burst_top i2cmrb_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_sda_out       (o_res.sda_out),
    .i_sda_is_output (o_res.sda_is_output),
    .i_read_valid    (o_res.read_valid),
    .i_read_data     (o_res.read_data),
    .i_read_last     (o_res.read_last),
    .i_done_res      (o_res.done_res),
    .i_status        (o_res.status),
    .i_busy_res      (o_res.busy_res)
);
